[rtl/core/sma_pkg.sv]
// Shared types and constants for the simple moving average block.
package sma_pkg;

  localparam int MAX_WINDOW = 256;
  localparam int SAMPLE_W   = 48;
  localparam int LEN_W      = $clog2(MAX_WINDOW + 1);
  localparam int PTR_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_W      = SAMPLE_W + PTR_W;
  localparam int CNT_W      = $clog2(SUM_W);

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic                       command;
    logic signed [SAMPLE_W-1:0] sample;
  } sma_in_t;

  typedef struct packed {
    logic                       ready_res;
    logic signed [SAMPLE_W-1:0] average;
  } sma_out_t;

endpackage

[rtl/core/sma_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/sma_div.sv]
// Radix-2 restoring divider: signed window sum over unsigned length, truncated toward zero.
module sma_div import sma_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic signed [SUM_W-1:0]    dividend,
  input  logic [LEN_W-1:0]           divisor,
  output logic                       done,
  output logic signed [SAMPLE_W-1:0] quotient
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic               neg_r, neg_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [LEN_W-1:0]   rem_r, rem_nxt;
  logic [SUM_W-1:0]   quo_r, quo_nxt;
  logic [LEN_W:0]     rem_sh;
  logic [LEN_W:0]     diff;
  logic [SUM_W-1:0]   quo_signed;

  assign rem_sh = {rem_r, quo_r[SUM_W-1]};
  assign diff   = rem_sh - {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      neg_nxt  = dividend[SUM_W-1];
      quo_nxt  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(SUM_W - 1);
    end else if (busy_r) begin
      // shift one dividend bit into the remainder, subtract when it fits
      if (!diff[LEN_W]) begin
        rem_nxt = diff[LEN_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[LEN_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign quo_signed = neg_r ? (~quo_r + 1'b1) : quo_r;
  assign quotient   = quo_signed[SAMPLE_W-1:0];
  assign done       = done_r;

endmodule

[rtl/core/simple_moving_average_top.sv]
// Simple moving average over a ring window of signed Q32.16 samples.
// Path from accept to output register: a push that leaves the window full passes the RAM read-back,
//   the one-bit-per-cycle divider and the staged result; a push that leaves it still filling skips
//   the divider, and a push while disabled goes straight to the staged result. One item in
//   flight: a new item is taken only in idle, a clear gives no result, and a stalled output register waits.
// Reset (synchronous, rst_n low): clears length, pointer, fill count, sum and valid flags.
module simple_moving_average_top import sma_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input item channel
  input  logic              in_valid,
  output logic              in_stall,
  input  sma_in_t           in_data,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output sma_out_t          out_data,
  // length register write
  input  logic              cfg_wr_en,
  input  logic [LEN_W-1:0]  cfg_window_length
);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;  // wait for an item
  localparam logic [1:0] ST_RD   = 2'd1;  // oldest sample arrives from RAM, write the new one
  localparam logic [1:0] ST_DIV  = 2'd2;  // divider running
  localparam logic [1:0] ST_OUT  = 2'd3;  // hand the staged result to the output register

  logic [1:0]        state_r, state_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic [LEN_W-1:0]  fill_r, fill_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              full_r, full_nxt;
  logic              start_r, start_nxt;
  logic [PTR_W-1:0]  addr_r, addr_nxt;
  logic [SAMPLE_W-1:0] sample_r, sample_nxt;
  sma_out_t          res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  sma_out_t          out_data_r, out_data_nxt;

  logic              accept;
  logic              out_free;
  logic [PTR_W-1:0]  ptr_cur;
  logic [LEN_W-1:0]  ptr_inc;
  logic              ram_we;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic              div_done;
  logic signed [SAMPLE_W-1:0] div_quo;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // wrap a stale pointer into the current window, then find the slot after it
  assign ptr_cur = (LEN_W'(ptr_r) >= len_r) ? '0 : ptr_r;
  assign ptr_inc = LEN_W'(ptr_cur) + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    ptr_nxt       = ptr_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    full_nxt      = full_r;
    start_nxt     = 1'b0;
    addr_nxt      = addr_r;
    sample_nxt    = sample_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;

    // drop the result once the consumer takes it
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.command == CMD_CLEAR) begin
            ptr_nxt  = '0;
            fill_nxt = '0;
            sum_nxt  = '0;
          end else if (len_r == '0) begin
            // disabled: answer not ready with zero, keep all state
            res_nxt   = '0;
            state_nxt = ST_OUT;
          end else begin
            // read the oldest slot, add the new sample now, subtract the old one next cycle if full
            addr_nxt   = ptr_cur;
            sample_nxt = in_data.sample;
            sum_nxt    = sum_r + {{(SUM_W-SAMPLE_W){in_data.sample[SAMPLE_W-1]}},
                                  in_data.sample};
            full_nxt   = (fill_r >= len_r);
            if (fill_r < len_r) begin
              fill_nxt = fill_r + 1'b1;
            end
            ptr_nxt   = (ptr_inc >= len_r) ? '0 : ptr_inc[PTR_W-1:0];
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        ram_we = 1'b1;
        if (full_r) begin
          sum_nxt = sum_r - {{(SUM_W-SAMPLE_W){ram_rdata[SAMPLE_W-1]}}, ram_rdata};
        end
        if (fill_r >= len_r) begin
          start_nxt = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          res_nxt   = '0;
          state_nxt = ST_OUT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_nxt.ready_res = 1'b1;
          res_nxt.average   = div_quo;
          state_nxt         = ST_OUT;
        end
      end
      ST_OUT: begin
        // hold the staged result until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // a length write saturates to MAX_WINDOW and empties the window
    if (cfg_wr_en) begin
      len_nxt  = (cfg_window_length > LEN_W'(MAX_WINDOW)) ? LEN_W'(MAX_WINDOW)
                                                          : cfg_window_length;
      ptr_nxt  = '0;
      fill_nxt = '0;
      sum_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      ptr_r       <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      full_r      <= 1'b0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      ptr_r       <= ptr_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      full_r      <= full_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    addr_r     <= addr_nxt;
    sample_r   <= sample_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // window store: written in the read-back cycle at the slot just read
  sma_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_window_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (sample_r),
    .raddr (ptr_cur),
    .rdata (ram_rdata)
  );

  // average = sum / length, started together with the registered final sum
  sma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .dividend (signed'(sum_r)),
    .divisor  (len_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
